/* rtl/cle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int          MAX_LINE  = 256;
	localparam int          CMD_DEPTH = 4;
	localparam int          CMD_AW    = $clog2(CMD_DEPTH);

	localparam logic [7:0]  CH_CR  = 8'h0D;
	localparam logic [7:0]  CH_LF  = 8'h0A;
	localparam logic [7:0]  CH_BS  = 8'h08;
	localparam logic [7:0]  CH_DEL = 8'h7F;
	localparam logic [7:0]  CH_SP  = 8'h20;

	// Effective capacity (at most 256) and that capacity minus one, the largest usable index.
	localparam int          CAP_LIMIT  = (MAX_LINE < 256) ? MAX_LINE : 256;
	localparam logic [7:0]  CAP_M1_MAX = 8'(CAP_LIMIT - 1);

	typedef enum logic [1:0] {
		CMD_STORE,
		CMD_LINE,
		CMD_ERASE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic [7:0] count;
	} cmd_t;

	typedef struct packed {
		logic wr;
		cmd_t cmd;
	} cmd_wr_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       store_valid;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic       line_done;
		logic [7:0] line_length;
		logic       last;
	} result_t;

endpackage
`default_nettype wire

/* rtl/cle_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cle_front
// Accepts received bytes, classifies them, keeps the character count and
// the capacity register, and queues one command per byte that has an effect.
// ----------------------------------------------------------------------------
module cle_front import cle_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] rx_byte,
	input  wire logic       q_full,
	input  wire logic       cfg_valid,
	input  wire logic [8:0] cfg_data,
	output cmd_wr_t         wr
);

	logic [7:0] count_q;
	logic [7:0] cap_m1_q;
	logic [7:0] cap_m1_d;
	logic       accept;
	logic       is_line;
	logic       is_erase;
	logic [7:0] count_d;

	always_comb begin
		if (cfg_data == 9'd0) begin
			cap_m1_d = 8'd0;
		end else if (cfg_data > 9'(CAP_LIMIT)) begin
			cap_m1_d = CAP_M1_MAX;
		end else begin
			cap_m1_d = 8'(cfg_data - 9'd1);
		end
	end

	always_comb begin
		accept       = push && !q_full;
		is_line      = (rx_byte == CH_CR) || (rx_byte == CH_LF);
		is_erase     = (rx_byte == CH_DEL) || (rx_byte == CH_BS);
		count_d      = count_q;
		wr.wr        = 1'b0;
		wr.cmd.data  = rx_byte;
		wr.cmd.count = count_q;
		wr.cmd.kind  = CMD_STORE;
		priority if (is_line) begin
			wr.cmd.kind = CMD_LINE;
			wr.wr       = accept;
			count_d     = 8'd0;
		end else if (is_erase) begin
			wr.cmd.kind = CMD_ERASE;
			if (count_q != 8'd0) begin
				wr.wr   = accept;
				count_d = count_q - 8'd1;
			end
		end else begin
			if (count_q < cap_m1_q) begin
				wr.wr   = accept;
				count_d = count_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 8'd0;
			cap_m1_q <= CAP_M1_MAX;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (cfg_valid) begin
				cap_m1_q <= cap_m1_d;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/cle_cmd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cle_cmd_fifo
// Short command queue between the classifying front and the echo back end.
// ----------------------------------------------------------------------------
module cle_cmd_fifo import cle_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_wr_t wr,
	input  wire logic    rd,
	output logic         full,
	output logic         head_valid,
	output cmd_t         head
);

	cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wptr_q;
	logic [CMD_AW-1:0] rptr_q;
	logic [CMD_AW:0]   level_q;
	logic              do_wr;
	logic              do_rd;

	assign full       = (level_q == (CMD_AW+1)'(CMD_DEPTH));
	assign head_valid = (level_q != '0);
	assign head       = mem_q[rptr_q];
	assign do_wr      = wr.wr && !full;
	assign do_rd      = rd && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			level_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/cle_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cle_back
// Expands each queued command into its echo and store results, one per
// cycle while the output register is free or popped, into a single output register.
// ----------------------------------------------------------------------------
module cle_back import cle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire cmd_t head,
	output logic      head_pop,
	input  wire logic pop,
	output logic      empty,
	output result_t   res
);

	logic [1:0] step_q;
	result_t    res_q;
	logic       out_valid_q;
	result_t    nxt;
	logic       advance;

	always_comb begin
		nxt = '0;
		unique case (head.kind)
			CMD_STORE: begin
				nxt.tx_byte     = head.data;
				nxt.store_valid = 1'b1;
				nxt.store_index = head.count;
				nxt.store_byte  = head.data;
				nxt.last        = 1'b1;
			end
			CMD_LINE: begin
				if (step_q == 2'd0) begin
					nxt.tx_byte = CH_CR;
				end else begin
					nxt.tx_byte     = CH_LF;
					nxt.store_valid = 1'b1;
					nxt.store_index = head.count;
					nxt.line_done   = 1'b1;
					nxt.line_length = head.count;
					nxt.last        = 1'b1;
				end
			end
			CMD_ERASE: begin
				nxt.tx_byte = (step_q == 2'd1) ? CH_SP : CH_BS;
				nxt.last    = (step_q == 2'd2);
			end
			default: begin
				nxt.last = 1'b1;
			end
		endcase
	end

	assign advance  = head_valid && (!out_valid_q || pop);
	assign head_pop = advance && nxt.last;
	assign empty    = !out_valid_q;
	assign res      = res_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= nxt.last ? 2'd0 : step_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/console_line_editor_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// console_line_editor_top
// Terminal line editor: echoes, stores and terminates received characters.
// ----------------------------------------------------------------------------
// Received bytes enter through push/full; a beat is taken when push is high
// and full is low. Results leave through empty/pop: the oldest result sits on
// the result ports while empty is low and is taken when pop is high.
// The capacity register is written through cfg_valid/cfg_data; cfg_ready is
// always high, and writes belong in idle periods only.
// The front takes one byte per cycle while its four-entry command queue has
// room. The back end drains it at one result per cycle while results are
// popped; a line end yields two results, a backspace three, a character one.
// The first result of a byte passes through the command queue and then the
// output register before it reaches the result ports.
// Bytes with no effect (backspace on an empty line, a character on a full
// line) produce no result and queue no command.
// If the receiver stops popping, the output register holds its result, the
// queue fills and full rises; nothing is lost.
// Reset clears the character count and the queue and sets capacity to 256.
// ----------------------------------------------------------------------------
module console_line_editor_top import cle_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      tx_byte,
	output logic            store_valid,
	output logic [7:0]      store_index,
	output logic [7:0]      store_byte,
	output logic            line_done,
	output logic [7:0]      line_length,
	output logic            last
);

	cmd_wr_t wr;
	logic    head_valid;
	cmd_t    head;
	logic    head_pop;
	result_t res;

	assign cfg_ready = 1'b1;

	cle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.q_full   (full),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.wr       (wr)
	);

	cle_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd        (head_pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	cle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.head_pop  (head_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign tx_byte     = res.tx_byte;
	assign store_valid = res.store_valid;
	assign store_index = res.store_index;
	assign store_byte  = res.store_byte;
	assign line_done   = res.line_done;
	assign line_length = res.line_length;
	assign last        = res.last;

	a_done_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && line_done) |-> (last && store_valid && tx_byte == CH_LF))
		else $error("line end result malformed");

	a_done_terminator: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && line_done) |-> (store_byte == 8'd0 && store_index == line_length))
		else $error("terminator store does not match line length");

	a_store_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && store_valid && !line_done) |-> (tx_byte == store_byte && last))
		else $error("character store does not echo its byte");

endmodule
`default_nettype wire
